// File: rtl/core/assert_macros.svh
// assertion macros shared by the envelope generator rtl
// no dependencies; bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/adsr_pkg.sv
// shared constants and types of the adsr envelope generator
// used by adsr_muldiv and adsr_envelope_generator_top; no dependencies
package adsr_pkg;

	localparam int TIME_FRAC_BITS  = 16;
	localparam int LEVEL_FRAC_BITS = 16;

	localparam int TIME_W  = 32;
	localparam int LEVEL_W = 17;
	localparam int MD_B_W  = TIME_W + 1;
	localparam int PROD_W  = MD_B_W + LEVEL_W;
	localparam int CNT_W   = $clog2(LEVEL_W);
	localparam int CFG_IDX_W = 3;

	localparam logic [TIME_W-1:0] T_ONE = TIME_W'(64'd1 << TIME_FRAC_BITS);
	localparam logic [TIME_W-1:0] T_JUMP =
		TIME_W'((64'd16 * (64'd1 << TIME_FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [TIME_W-1:0] T_FLOOR =
		TIME_W'(((64'd1 << TIME_FRAC_BITS) + 64'd999) / 64'd1000);
	localparam logic [LEVEL_W-1:0] L_ONE = LEVEL_W'(64'd1 << LEVEL_FRAC_BITS);

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TIME   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_TIME    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIME  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_DURATION = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX       = 3'd7;

	// request to the serial multiply / divide unit: (a * b) / d, or a * b alone
	typedef struct packed {
		logic                      start;
		logic                      div;
		logic [LEVEL_W-1:0]        a;
		logic signed [MD_B_W-1:0]  b;
		logic [TIME_W-1:0]         d;
	} md_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [PROD_W-1:0]  prod;
		logic [LEVEL_W-1:0]        quo;
	} md_rsp_t;

endpackage

// File: rtl/core/adsr_muldiv.sv
// bit-serial multiply (shift-add) followed by optional restoring divide
// depends on adsr_pkg and assert_macros.svh
`include "assert_macros.svh"

module adsr_muldiv import adsr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_phase_t;

	md_phase_t            phase_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic                 div_q;
	logic [LEVEL_W-1:0]   a_q;
	logic [PROD_W-1:0]    b_q;
	logic [PROD_W-1:0]    acc_q;
	logic [TIME_W-1:0]    d_q;
	logic [TIME_W-1:0]    rem_q;
	logic [LEVEL_W-1:0]   lo_q;
	logic [LEVEL_W-1:0]   quo_q;

	logic [PROD_W-1:0]    acc_sum;
	logic [TIME_W:0]      r2;
	logic [TIME_W+1:0]    r2_diff;
	logic                 fits;

	always_comb begin
		acc_sum = acc_q + (a_q[0] ? b_q : '0);
		r2      = {rem_q, lo_q[LEVEL_W-1]};
		r2_diff = {1'b0, r2} - {2'b00, d_q};
		fits    = !r2_diff[TIME_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			div_q   <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			acc_q   <= '0;
			d_q     <= '0;
			rem_q   <= '0;
			lo_q    <= '0;
			quo_q   <= '0;
		end else begin
			// one-cycle pulse on the last step of the final phase
			done_q <= (cnt_q == '0) && ((phase_q == MD_MUL && !div_q) || phase_q == MD_DIV);
			unique case (phase_q)
				MD_IDLE: begin
					if (req.start) begin
						a_q     <= req.a;
						b_q     <= {{(PROD_W-MD_B_W){req.b[MD_B_W-1]}}, req.b};
						acc_q   <= '0;
						d_q     <= req.d;
						div_q   <= req.div;
						cnt_q   <= CNT_W'(LEVEL_W - 1);
						phase_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					acc_q <= acc_sum;
					b_q   <= b_q << 1;
					a_q   <= a_q >> 1;
					if (cnt_q == '0) begin
						if (div_q) begin
							// quotient fits LEVEL_W bits, so the top part is below d
							rem_q   <= acc_sum[LEVEL_W +: TIME_W];
							lo_q    <= acc_sum[LEVEL_W-1:0];
							cnt_q   <= CNT_W'(LEVEL_W - 1);
							phase_q <= MD_DIV;
						end else begin
							phase_q <= MD_IDLE;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				MD_DIV: begin
					rem_q <= fits ? r2_diff[TIME_W-1:0] : r2[TIME_W-1:0];
					lo_q  <= lo_q << 1;
					quo_q <= {quo_q[LEVEL_W-2:0], fits};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						phase_q <= MD_IDLE;
				end
				default: phase_q <= MD_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;
	assign rsp.quo  = quo_q;

	`ASSERT_IMPLIES(a_md_start_idle, clk, arst_n, req.start, phase_q == MD_IDLE, "start while busy")
	`ASSERT_NEXT(a_md_done_pulse, clk, arst_n, done_q, !done_q, "done longer than one cycle")
	`ASSERT_IMPLIES(a_md_rem_below, clk, arst_n, phase_q == MD_DIV, rem_q < d_q, "remainder overflow")

endmodule

// File: rtl/core/adsr_envelope_generator_top.sv
// one item in work at a time; in_ready returns with the result, once the output register
// is free, so a stalled receiver holds the flow; each item runs the serial muldiv unit,
// whose multiply and divide phases are 17 steps each, once for the mapping or twice
// when a ramp division runs for frames inside attack, decay or release
// asynchronous active-low reset returns registers to defaults and the envelope to idle
// depends on adsr_pkg, adsr_muldiv and assert_macros.svh
`include "assert_macros.svh"

module adsr_envelope_generator_top import adsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 gate,
	input  logic [TIME_W-1:0]    time_now,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   mapped_value,
	output logic [LEVEL_W-1:0]   envelope_level,
	output logic                 is_active
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	typedef enum logic [2:0] {
		F_IDLE, F_DT, F_ADD, F_CMP, F_RAMP, F_MAP, F_MAPW, F_OUT
	} fsm_t;

	// configuration, lengths stored already floored and sustain clamped
	logic                trig_q;
	logic [TIME_W-1:0]   att_q, dec_q, rel_q, hold_q;
	logic [LEVEL_W-1:0]  sus_q;
	logic [31:0]         min_q, max_q;

	// envelope state
	stage_t              stage_q;
	logic [TIME_W-1:0]   se_q, total_q, last_q;
	logic                prev_q, seen_q;
	logic [LEVEL_W-1:0]  level_q, rfl_q;

	fsm_t                fsm_q;
	logic                gate_q;
	logic [TIME_W-1:0]   now_q, dt_q;

	logic                out_valid_q;
	logic [31:0]         mapped_q;
	logic [LEVEL_W-1:0]  lvl_out_q;
	logic                active_q;

	md_req_t             md_req;
	md_rsp_t             md_rsp;

	logic [TIME_W-1:0]   last_eff, diff_t, dt_new;
	logic                rising, falling;
	stage_t              stage_tr;
	logic                se_clr, tot_clr, cap;
	logic [TIME_W:0]     se_sum, tot_sum;
	logic [TIME_W-1:0]   se_sat, tot_sat;
	logic                ramp_go;
	logic [PROD_W-LEVEL_FRAC_BITS:0] map_sum;
	logic [31:0]         map_sat;

	adsr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	// frame delta time
	always_comb begin
		last_eff = seen_q ? last_q : now_q;
		diff_t   = now_q - last_eff;
		dt_new   = (diff_t[TIME_W-1] || diff_t > T_ONE) ? T_JUMP : diff_t;
	end

	// stage transitions from the gate or the hold time
	always_comb begin
		rising   = gate_q && !prev_q;
		falling  = !gate_q && prev_q;
		stage_tr = stage_q;
		se_clr   = 1'b0;
		tot_clr  = 1'b0;
		cap      = 1'b0;
		if (!trig_q) begin
			if (rising) begin
				stage_tr = ST_ATTACK;
				se_clr   = 1'b1;
				cap      = 1'b1;
			end else if (falling && stage_q != ST_IDLE) begin
				stage_tr = ST_RELEASE;
				se_clr   = 1'b1;
				cap      = 1'b1;
			end
		end else begin
			if (rising) begin
				stage_tr = ST_ATTACK;
				se_clr   = 1'b1;
				tot_clr  = 1'b1;
				cap      = 1'b1;
			end else if (stage_q != ST_IDLE && stage_q != ST_RELEASE &&
					hold_q != '0 && total_q >= hold_q) begin
				stage_tr = ST_RELEASE;
				se_clr   = 1'b1;
				cap      = 1'b1;
			end
		end
	end

	always_comb begin
		se_sum  = {1'b0, se_q} + {1'b0, dt_q};
		tot_sum = {1'b0, total_q} + {1'b0, dt_q};
		se_sat  = se_sum[TIME_W] ? '1 : se_sum[TIME_W-1:0];
		tot_sat = tot_sum[TIME_W] ? '1 : tot_sum[TIME_W-1:0];
	end

	// operands for the serial unit
	always_comb begin
		md_req  = '0;
		ramp_go = 1'b0;
		unique case (fsm_q)
			F_CMP: begin
				md_req.div = 1'b1;
				md_req.b   = {1'b0, se_q};
				unique case (stage_q)
					ST_ATTACK: begin
						ramp_go  = se_q < att_q;
						md_req.a = L_ONE;
						md_req.d = att_q;
					end
					ST_DECAY: begin
						ramp_go  = se_q < dec_q;
						md_req.a = L_ONE - sus_q;
						md_req.d = dec_q;
					end
					ST_RELEASE: begin
						ramp_go  = se_q < rel_q;
						md_req.a = rfl_q;
						md_req.b = {1'b0, rel_q - se_q};
						md_req.d = rel_q;
					end
					default: ramp_go = 1'b0;
				endcase
				md_req.start = ramp_go;
			end
			F_MAP: begin
				md_req.start = 1'b1;
				md_req.div   = 1'b0;
				md_req.a     = level_q;
				md_req.b     = {max_q[31], max_q} - {min_q[31], min_q};
			end
			default: md_req = '0;
		endcase
	end

	// out_min plus floor(range * level / 2^L), saturated
	always_comb begin
		map_sum = {{(PROD_W-LEVEL_FRAC_BITS-31){min_q[31]}}, min_q}
			+ {md_rsp.prod[PROD_W-1], md_rsp.prod[PROD_W-1:LEVEL_FRAC_BITS]};
		if (map_sum[PROD_W-LEVEL_FRAC_BITS:31] == '0 || map_sum[PROD_W-LEVEL_FRAC_BITS:31] == '1)
			map_sat = map_sum[31:0];
		else if (map_sum[PROD_W-LEVEL_FRAC_BITS])
			map_sat = SAT_MIN;
		else
			map_sat = SAT_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q      <= 1'b0;
			att_q       <= 32'd655;
			dec_q       <= 32'd6554;
			sus_q       <= 17'd45875;
			rel_q       <= 32'd19661;
			hold_q      <= '0;
			min_q       <= '0;
			max_q       <= '0;
			stage_q     <= ST_IDLE;
			se_q        <= '0;
			total_q     <= '0;
			last_q      <= '0;
			prev_q      <= 1'b0;
			seen_q      <= 1'b0;
			level_q     <= '0;
			rfl_q       <= '0;
			fsm_q       <= F_IDLE;
			gate_q      <= 1'b0;
			now_q       <= '0;
			dt_q        <= '0;
			out_valid_q <= 1'b0;
			mapped_q    <= '0;
			lvl_out_q   <= '0;
			active_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TRIGGER_MODE:  trig_q <= cfg_data[0];
					REG_ATTACK_TIME:   att_q  <= (cfg_data < T_FLOOR) ? T_FLOOR : cfg_data;
					REG_DECAY_TIME:    dec_q  <= (cfg_data < T_FLOOR) ? T_FLOOR : cfg_data;
					REG_SUSTAIN_LEVEL: sus_q  <= (cfg_data[LEVEL_W-1:0] > L_ONE) ?
						L_ONE : cfg_data[LEVEL_W-1:0];
					REG_RELEASE_TIME:  rel_q  <= (cfg_data < T_FLOOR) ? T_FLOOR : cfg_data;
					REG_HOLD_DURATION: hold_q <= cfg_data;
					REG_OUT_MIN:       min_q  <= cfg_data;
					REG_OUT_MAX:       max_q  <= cfg_data;
					default:           trig_q <= trig_q;
				endcase
			end

			// in F_OUT the output register is refilled instead
			if (out_valid_q && out_ready && fsm_q != F_OUT)
				out_valid_q <= 1'b0;

			unique case (fsm_q)
				F_IDLE: begin
					if (in_valid) begin
						gate_q <= gate;
						now_q  <= time_now;
						fsm_q  <= F_DT;
					end
				end
				F_DT: begin
					dt_q    <= dt_new;
					last_q  <= now_q;
					seen_q  <= 1'b1;
					prev_q  <= gate_q;
					stage_q <= stage_tr;
					if (se_clr)
						se_q <= '0;
					if (tot_clr)
						total_q <= '0;
					if (cap)
						rfl_q <= level_q;
					fsm_q <= F_ADD;
				end
				F_ADD: begin
					se_q <= se_sat;
					if (stage_q != ST_RELEASE && stage_q != ST_IDLE)
						total_q <= tot_sat;
					fsm_q <= F_CMP;
				end
				F_CMP: begin
					if (ramp_go) begin
						fsm_q <= F_RAMP;
					end else begin
						fsm_q <= F_MAP;
						unique case (stage_q)
							ST_ATTACK: begin
								level_q <= L_ONE;
								stage_q <= ST_DECAY;
								se_q    <= '0;
							end
							ST_DECAY: begin
								level_q <= sus_q;
								stage_q <= ST_SUSTAIN;
								se_q    <= '0;
							end
							ST_SUSTAIN: level_q <= sus_q;
							ST_RELEASE: begin
								level_q <= '0;
								stage_q <= ST_IDLE;
								se_q    <= '0;
							end
							default: begin
								level_q <= '0;
								stage_q <= ST_IDLE;
							end
						endcase
					end
				end
				F_RAMP: begin
					if (md_rsp.done) begin
						level_q <= (stage_q == ST_DECAY) ? L_ONE - md_rsp.quo : md_rsp.quo;
						fsm_q   <= F_MAP;
					end
				end
				F_MAP: fsm_q <= F_MAPW;
				F_MAPW: begin
					if (md_rsp.done)
						fsm_q <= F_OUT;
				end
				F_OUT: begin
					// wait until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						mapped_q    <= map_sat;
						lvl_out_q   <= level_q;
						active_q    <= stage_q != ST_IDLE;
						fsm_q       <= F_IDLE;
					end
				end
				default: fsm_q <= F_IDLE;
			endcase
		end
	end

	assign in_ready       = fsm_q == F_IDLE;
	assign out_valid      = out_valid_q;
	assign mapped_value   = mapped_q;
	assign envelope_level = lvl_out_q;
	assign is_active      = active_q;

	`ASSERT_IMPLIES(a_level_range, clk, arst_n, out_valid, envelope_level <= L_ONE, "level above one")
	`ASSERT_IMPLIES(a_idle_zero, clk, arst_n, out_valid && !is_active, envelope_level == '0, "idle with level")
	`ASSERT_IMPLIES(a_done_when_waiting, clk, arst_n, md_rsp.done, fsm_q == F_RAMP || fsm_q == F_MAPW, "unexpected done")
	`ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, fsm_q == F_DT, "item not taken up")

endmodule

// File: tb/sv/adsr_envelope_generator_top_test.sv
// self-checking testbench for adsr_envelope_generator_top: gate/timestamp frames in,
// mapped level out, checked against an in-bench envelope predictor
// depends on adsr_pkg and the adsr_envelope_generator_top rtl
`timescale 1ns / 100ps

module adsr_envelope_generator_top_test;
	import adsr_pkg::*;

	localparam int CYCLE_LIMIT      = 1000000;
	localparam int DRAIN_CYCLES     = 70;
	localparam int FRAMES_PER_PHASE = 86;
	localparam int RANDOM_PHASES    = 12;
	localparam int REG_COUNT        = 1 << CFG_IDX_W;

	typedef enum logic [2:0] {
		STG_IDLE    = 3'd0,
		STG_ATTACK  = 3'd1,
		STG_DECAY   = 3'd2,
		STG_SUSTAIN = 3'd3,
		STG_RELEASE = 3'd4
	} env_stage_t;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SPARSE,
		RDY_LONG
	} ready_style_t;

	typedef struct packed {
		logic              gate;
		logic [TIME_W-1:0] stamp;
	} frame_t;

	typedef struct packed {
		logic [31:0]        mapped;
		logic [LEVEL_W-1:0] level;
		logic               active;
	} env_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 gate = 1'b0;
	logic [TIME_W-1:0]    time_now = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [31:0]   mapped_value;
	logic [LEVEL_W-1:0]   envelope_level;
	logic                 is_active;

	// predictor copy of the registers, reset values
	logic               m_trigger = 1'b0;
	logic [31:0]        m_attack = 32'd655;
	logic [31:0]        m_decay = 32'd6554;
	logic [LEVEL_W-1:0] m_sustain = 17'd45875;
	logic [31:0]        m_release = 32'd19661;
	logic [31:0]        m_hold = 32'd0;
	logic signed [31:0] m_out_min = 32'sd0;
	logic signed [31:0] m_out_max = 32'sd0;

	// predictor copy of the envelope state
	env_stage_t        st_stage = STG_IDLE;
	logic [31:0]       st_stage_time = '0;
	logic [31:0]       st_total_time = '0;
	logic              st_prev_gate = 1'b0;
	logic [63:0]       st_release_from = '0;
	logic [TIME_W-1:0] st_last_time = '0;
	logic [63:0]       st_level = '0;
	logic              st_started = 1'b0;

	frame_t      frame_backlog[$];
	env_result_t due_outputs[$];
	logic [31:0] reg_image[REG_COUNT];
	logic [31:0] tcur = '0;

	int mismatch_count = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	ready_style_t ready_style = RDY_ALWAYS;
	int style_left = 0;
	int stall_left = 0;
	logic [1:0] ready_tick = '0;
	frame_t next_frame;
	env_result_t want;

	adsr_envelope_generator_top DUT (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.in_valid,
		.in_ready,
		.gate,
		.time_now,
		.out_valid,
		.out_ready,
		.mapped_value,
		.envelope_level,
		.is_active
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** adsr_envelope_generator_top: FAILED **");
			$finish;
		end
	end

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// advances the envelope by one frame and returns what the block should emit
	function automatic env_result_t advance_envelope(input logic g, input logic [TIME_W-1:0] now);
		logic [63:0]       att, dec, rel, sus;
		logic [TIME_W-1:0] diff, dt;
		logic              rising, falling;
		longint            span, prod, mapped;
		env_result_t       r;
		att = (m_attack < T_FLOOR) ? 64'(T_FLOOR) : 64'(m_attack);
		dec = (m_decay < T_FLOOR) ? 64'(T_FLOOR) : 64'(m_decay);
		rel = (m_release < T_FLOOR) ? 64'(T_FLOOR) : 64'(m_release);
		sus = (m_sustain > L_ONE) ? 64'(L_ONE) : 64'(m_sustain);
		rising = g && !st_prev_gate;
		falling = !g && st_prev_gate;
		st_prev_gate = g;
		if (!st_started) begin
			st_last_time = now;
			st_started = 1'b1;
		end
		diff = now - st_last_time;
		st_last_time = now;
		// backward steps and gaps over one second count as one nominal frame
		dt = (diff[TIME_W-1] || diff > T_ONE) ? T_JUMP : diff;

		if (!m_trigger) begin
			if (rising) begin
				st_stage = STG_ATTACK;
				st_stage_time = '0;
				st_release_from = st_level;
			end else if (falling && st_stage != STG_IDLE) begin
				st_stage = STG_RELEASE;
				st_stage_time = '0;
				st_release_from = st_level;
			end
		end else begin
			if (rising) begin
				st_stage = STG_ATTACK;
				st_stage_time = '0;
				st_total_time = '0;
				st_release_from = st_level;
			end
			if (st_stage != STG_IDLE && st_stage != STG_RELEASE && m_hold != 0 &&
					st_total_time >= m_hold) begin
				st_stage = STG_RELEASE;
				st_stage_time = '0;
				st_release_from = st_level;
			end
		end

		st_stage_time = sat_add32(st_stage_time, dt);
		if (st_stage != STG_RELEASE && st_stage != STG_IDLE)
			st_total_time = sat_add32(st_total_time, dt);

		case (st_stage)
			STG_ATTACK: begin
				if (64'(st_stage_time) < att) begin
					st_level = (64'(st_stage_time) * 64'(L_ONE)) / att;
				end else begin
					st_level = 64'(L_ONE);
					st_stage = STG_DECAY;
					st_stage_time = '0;
				end
			end
			STG_DECAY: begin
				if (64'(st_stage_time) < dec) begin
					st_level = 64'(L_ONE) - (64'(st_stage_time) * (64'(L_ONE) - sus)) / dec;
				end else begin
					st_level = sus;
					st_stage = STG_SUSTAIN;
					st_stage_time = '0;
				end
			end
			STG_SUSTAIN: begin
				st_level = sus;
			end
			STG_RELEASE: begin
				if (64'(st_stage_time) < rel) begin
					st_level = (st_release_from * (rel - 64'(st_stage_time))) / rel;
				end else begin
					st_level = '0;
					st_stage = STG_IDLE;
					st_stage_time = '0;
				end
			end
			default: begin
				st_stage = STG_IDLE;
				st_level = '0;
			end
		endcase
		if (st_level > 64'(L_ONE))
			st_level = 64'(L_ONE);

		// arithmetic shift floors, so negative products round toward minus infinity
		span = longint'(m_out_max) - longint'(m_out_min);
		prod = span * longint'(st_level);
		mapped = longint'(m_out_min) + (prod >>> LEVEL_FRAC_BITS);
		if (mapped > longint'(SAT_MAX))
			mapped = longint'(SAT_MAX);
		if (mapped < longint'($signed(SAT_MIN)))
			mapped = longint'($signed(SAT_MIN));

		r.mapped = mapped[31:0];
		r.level = (st_level > 64'h1FFFF) ? {LEVEL_W{1'b1}} : st_level[LEVEL_W-1:0];
		r.active = (st_stage != STG_IDLE);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 200)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	function automatic void push_step(input logic g, input logic [31:0] delta);
		frame_t f;
		tcur = tcur + delta;
		f.gate = g;
		f.stamp = tcur;
		frame_backlog.push_back(f);
	endfunction

	function automatic logic [31:0] pick_length();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 5))
				0: return 32'd0;
				1: return T_FLOOR - 1;
				2: return T_FLOOR;
				3: return T_FLOOR + 1;
				4: return 32'hFFFF_FFFF;
				default: return $urandom;
			endcase
		end
		return $urandom_range(0, 24000);
	endfunction

	function automatic logic [31:0] pick_output();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 2))
					0: return SAT_MIN;
					1: return SAT_MAX;
					default: return 32'd0;
				endcase
			end
			1: return $urandom;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	// one register write per clock; caller lowers cfg_we afterwards
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TRIGGER_MODE:  m_trigger = data[0];
			REG_ATTACK_TIME:   m_attack = data;
			REG_DECAY_TIME:    m_decay = data;
			REG_SUSTAIN_LEVEL: m_sustain = data[LEVEL_W-1:0];
			REG_RELEASE_TIME:  m_release = data;
			REG_HOLD_DURATION: m_hold = data;
			REG_OUT_MIN:       m_out_min = data;
			REG_OUT_MAX:       m_out_max = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings();
		for (int i = 0; i < REG_COUNT; i++)
			write_reg(CFG_IDX_W'(i), reg_image[i]);
		cfg_we <= 1'b0;
	endtask

	// holds the sender back until every issued item has come out, then lets the block settle
	task automatic wait_drained();
		while (frame_backlog.size() != 0 || in_valid || due_outputs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sender: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				due_outputs.push_back(advance_envelope(gate, time_now));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (frame_backlog.size() != 0) begin
					next_frame = frame_backlog.pop_front();
					in_valid <= 1'b1;
					gate <= next_frame.gate;
					time_now <= next_frame.stamp;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1, 2: gap_left = $urandom_range(1, 6);
							default: gap_left = $urandom_range(7, 70);
						endcase
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result and stalls in changing styles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_outputs.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no item waiting",
						results_seen));
				end else begin
					want = due_outputs.pop_front();
					if (mapped_value !== want.mapped)
						report_mismatch($sformatf("result %0d mapped_value %h, expected %h",
							results_seen, mapped_value, want.mapped));
					if (envelope_level !== want.level)
						report_mismatch($sformatf("result %0d envelope_level %h, expected %h",
							results_seen, envelope_level, want.level));
					if (is_active !== want.active)
						report_mismatch($sformatf("result %0d is_active %b, expected %b",
							results_seen, is_active, want.active));
				end
			end
			if (style_left == 0) begin
				ready_style = ready_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(50, 300);
			end else begin
				style_left--;
			end
			ready_tick++;
			case (ready_style)
				RDY_ALWAYS: out_ready <= 1'b1;
				RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: out_ready <= (ready_tick == 2'b11);
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						out_ready <= 1'b0;
					end else begin
						stall_left = $urandom_range(5, 40);
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	initial begin
		int made, held, span_frames;
		logic g;
		logic [31:0] advance;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default settings: first frame, a full gate cycle into idle
		tcur = 32'h89AB_CDEF;
		@(negedge clk);
		push_step(1'b0, 32'd0);
		push_step(1'b1, 32'd1000);
		push_step(1'b1, 32'd1000);
		push_step(1'b0, 32'd2000);
		push_step(1'b0, 32'd30000);
		push_step(1'b0, 32'd100);
		wait_drained();

		// floored attack, full output span, timestamp corner cases
		reg_image[REG_TRIGGER_MODE] = 32'd0;
		reg_image[REG_ATTACK_TIME] = 32'd0;
		reg_image[REG_DECAY_TIME] = 32'd1;
		reg_image[REG_SUSTAIN_LEVEL] = 32'(L_ONE);
		reg_image[REG_RELEASE_TIME] = 32'hFFFF_FFFF;
		reg_image[REG_HOLD_DURATION] = 32'd0;
		reg_image[REG_OUT_MIN] = SAT_MIN;
		reg_image[REG_OUT_MAX] = SAT_MAX;
		apply_settings();
		@(negedge clk);
		push_step(1'b1, 32'd10);
		push_step(1'b1, T_ONE);
		push_step(1'b1, T_ONE + 1);
		push_step(1'b0 ^ 1'b1, 32'hFFFF_FFFB);
		push_step(1'b0, 32'd20);
		push_step(1'b1, 32'd30);
		tcur = 32'hFFFF_FFF0;
		push_step(1'b0, 32'd0);
		push_step(1'b0, 32'h20);
		push_step(1'b0, 32'd0);
		wait_drained();

		// trigger mode: forced release after hold, clamped sustain, inverted span
		reg_image[REG_TRIGGER_MODE] = 32'd1;
		reg_image[REG_ATTACK_TIME] = 32'hFFFF_FFFF;
		reg_image[REG_DECAY_TIME] = 32'h8000_0000;
		reg_image[REG_SUSTAIN_LEVEL] = 32'h1_FFFF;
		reg_image[REG_RELEASE_TIME] = 32'd0;
		reg_image[REG_HOLD_DURATION] = 32'd3000;
		reg_image[REG_OUT_MIN] = SAT_MAX;
		reg_image[REG_OUT_MAX] = SAT_MIN;
		apply_settings();
		@(negedge clk);
		push_step(1'b1, 32'd1000);
		push_step(1'b1, 32'd2500);
		push_step(1'b1, 32'd1000);
		push_step(1'b1, 32'd1000);
		wait_drained();

		// back to gate mode with gate still high and the envelope idle
		reg_image[REG_TRIGGER_MODE] = 32'd0;
		write_reg(REG_TRIGGER_MODE, reg_image[REG_TRIGGER_MODE]);
		cfg_we <= 1'b0;
		@(negedge clk);
		push_step(1'b0, 32'd1000);
		push_step(1'b1, 32'd500);
		push_step(1'b0, T_ONE);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_drained();
			if (ph == 0) begin
				reg_image[REG_TRIGGER_MODE] = 32'd1;
				reg_image[REG_ATTACK_TIME] = 32'd0;
				reg_image[REG_DECAY_TIME] = 32'd0;
				reg_image[REG_SUSTAIN_LEVEL] = 32'd0;
				reg_image[REG_RELEASE_TIME] = 32'd0;
				reg_image[REG_HOLD_DURATION] = 32'd1;
				reg_image[REG_OUT_MIN] = SAT_MIN;
				reg_image[REG_OUT_MAX] = SAT_MIN;
			end else if (ph == 1) begin
				reg_image[REG_TRIGGER_MODE] = 32'd0;
				reg_image[REG_ATTACK_TIME] = 32'hFFFF_FFFF;
				reg_image[REG_DECAY_TIME] = 32'hFFFF_FFFF;
				reg_image[REG_SUSTAIN_LEVEL] = 32'h1_FFFF;
				reg_image[REG_RELEASE_TIME] = 32'hFFFF_FFFF;
				reg_image[REG_HOLD_DURATION] = 32'hFFFF_FFFF;
				reg_image[REG_OUT_MIN] = SAT_MAX;
				reg_image[REG_OUT_MAX] = SAT_MAX;
			end else begin
				reg_image[REG_TRIGGER_MODE] = $urandom_range(0, 1);
				reg_image[REG_ATTACK_TIME] = pick_length();
				reg_image[REG_DECAY_TIME] = pick_length();
				reg_image[REG_RELEASE_TIME] = pick_length();
				reg_image[REG_SUSTAIN_LEVEL] = ($urandom_range(0, 5) == 0) ?
					$urandom_range(L_ONE, 17'h1_FFFF) : $urandom_range(0, L_ONE);
				case ($urandom_range(0, 5))
					0, 1: reg_image[REG_HOLD_DURATION] = 32'd0;
					2: reg_image[REG_HOLD_DURATION] = 32'hFFFF_FFFF;
					default: reg_image[REG_HOLD_DURATION] = $urandom_range(1, 50000);
				endcase
				reg_image[REG_OUT_MIN] = pick_output();
				reg_image[REG_OUT_MAX] = pick_output();
			end
			apply_settings();
			@(negedge clk);

			// mostly press/hold/release notes with realistic frame steps, some noise
			made = 0;
			while (made < FRAMES_PER_PHASE) begin
				held = $urandom_range(1, 40);
				span_frames = held + $urandom_range(1, 25);
				for (int i = 0; i < span_frames && made < FRAMES_PER_PHASE; i++) begin
					g = (i < held);
					case ($urandom_range(0, 31))
						0: advance = $urandom;
						1: advance = T_ONE + $urandom_range(0, 2) - 1;
						2: advance = 32'd0;
						3: begin
							advance = $urandom_range(0, 3000);
							g = !g;
						end
						default: advance = $urandom_range(0, 3000);
					endcase
					push_step(g, advance);
					made++;
				end
			end
		end

		wait_drained();
		if (mismatch_count == 0)
			$display("** adsr_envelope_generator_top: PASSED **");
		else
			$display("** adsr_envelope_generator_top: FAILED **");
		$finish;
	end

endmodule
